### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the qrs_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define QRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// invariant checked on every clock edge outside reset
`define QRS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

### sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, status codes and pipeline sideband for the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int COEF_W  = 16;
  localparam int FRAC    = 16;
  localparam int ROOT_W  = 35;
  localparam int DISC_W  = 2 * COEF_W + 3;
  localparam int SQ_W    = 33;
  localparam int RAD_W   = 2 * SQ_W;
  localparam int REM_W   = SQ_W + 2;
  localparam int MAG_W   = ROOT_W - 1;
  localparam int DEN_W   = COEF_W + 1;
  localparam int DREM_W  = DEN_W;
  localparam int BASE_W  = COEF_W + FRAC + 1;
  // front two stages, square root, add, magnitude, divide, output
  localparam int LATENCY = 2 + SQ_W + 2 + MAG_W + 1;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_NONE  = 2'd1,
    ST_BAD_A = 2'd2
  } status_t;

  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic signed [BASE_W-1:0] base;
    logic [DEN_W-1:0]         den;
    logic                     neg_p;
    logic                     neg_m;
  } meta_t;

endpackage

`default_nettype wire

### sv/qrs_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire qrs_pkg::meta_t            meta_in,
  input  wire logic [qrs_pkg::RAD_W-1:0] rad_in,
  output qrs_pkg::meta_t                 meta_out,
  output logic [qrs_pkg::SQ_W-1:0]       root_out
);

  qrs_pkg::meta_t                  meta [0:qrs_pkg::SQ_W];
  logic [qrs_pkg::RAD_W-1:0]       rad  [0:qrs_pkg::SQ_W];
  logic [qrs_pkg::REM_W-1:0]       rem  [0:qrs_pkg::SQ_W];
  logic [qrs_pkg::SQ_W-1:0]        root [0:qrs_pkg::SQ_W];

  // stage zero is the registered input from the front end
  assign meta[0] = meta_in;
  assign rad[0]  = rad_in;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < qrs_pkg::SQ_W; i++) begin : g_stage
    logic [qrs_pkg::REM_W+1:0] cur;
    logic [qrs_pkg::REM_W+1:0] trial;

    // bring down two radicand bits and try the next root bit
    assign cur   = {rem[i], rad[i][qrs_pkg::RAD_W-1 -: 2]};
    assign trial = {2'b00, root[i], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        meta[i+1].valid <= 1'b0;
      end else begin
        meta[i+1] <= meta[i];
      end
      rad[i+1] <= {rad[i][qrs_pkg::RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem[i+1]  <= qrs_pkg::REM_W'(cur - trial);
        root[i+1] <= {root[i][qrs_pkg::SQ_W-2:0], 1'b1};
      end else begin
        rem[i+1]  <= qrs_pkg::REM_W'(cur);
        root[i+1] <= {root[i][qrs_pkg::SQ_W-2:0], 1'b0};
      end
    end
  end

  assign meta_out = meta[qrs_pkg::SQ_W];
  assign root_out = root[qrs_pkg::SQ_W];

endmodule

`default_nettype wire

### sv/qrs_div_pipe.sv
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire qrs_pkg::meta_t            meta_in,
  input  wire logic [qrs_pkg::MAG_W-1:0] mag_p_in,
  input  wire logic [qrs_pkg::MAG_W-1:0] mag_m_in,
  output qrs_pkg::meta_t                 meta_out,
  output logic [qrs_pkg::MAG_W-1:0]      quo_p,
  output logic [qrs_pkg::MAG_W-1:0]      quo_m
);

  qrs_pkg::meta_t               meta [0:qrs_pkg::MAG_W];
  logic [qrs_pkg::MAG_W-1:0]    np   [0:qrs_pkg::MAG_W];
  logic [qrs_pkg::MAG_W-1:0]    nm   [0:qrs_pkg::MAG_W];
  logic [qrs_pkg::DREM_W-1:0]   rp   [0:qrs_pkg::MAG_W];
  logic [qrs_pkg::DREM_W-1:0]   rm   [0:qrs_pkg::MAG_W];
  logic [qrs_pkg::MAG_W-1:0]    qp   [0:qrs_pkg::MAG_W];
  logic [qrs_pkg::MAG_W-1:0]    qm   [0:qrs_pkg::MAG_W];

  assign meta[0] = meta_in;
  assign np[0]   = mag_p_in;
  assign nm[0]   = mag_m_in;
  assign rp[0]   = '0;
  assign rm[0]   = '0;
  assign qp[0]   = '0;
  assign qm[0]   = '0;

  for (genvar i = 0; i < qrs_pkg::MAG_W; i++) begin : g_stage
    logic [qrs_pkg::DREM_W:0] cur_p;
    logic [qrs_pkg::DREM_W:0] cur_m;
    logic [qrs_pkg::DREM_W:0] den_x;

    // shift in the next dividend bit on both lanes
    assign cur_p = {rp[i], np[i][qrs_pkg::MAG_W-1]};
    assign cur_m = {rm[i], nm[i][qrs_pkg::MAG_W-1]};
    assign den_x = {1'b0, meta[i].den};

    always_ff @(posedge clk) begin
      if (rst) begin
        meta[i+1].valid <= 1'b0;
      end else begin
        meta[i+1] <= meta[i];
      end
      np[i+1] <= {np[i][qrs_pkg::MAG_W-2:0], 1'b0};
      nm[i+1] <= {nm[i][qrs_pkg::MAG_W-2:0], 1'b0};
      if (cur_p >= den_x) begin
        rp[i+1] <= qrs_pkg::DREM_W'(cur_p - den_x);
        qp[i+1] <= {qp[i][qrs_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rp[i+1] <= qrs_pkg::DREM_W'(cur_p);
        qp[i+1] <= {qp[i][qrs_pkg::MAG_W-2:0], 1'b0};
      end
      if (cur_m >= den_x) begin
        rm[i+1] <= qrs_pkg::DREM_W'(cur_m - den_x);
        qm[i+1] <= {qm[i][qrs_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rm[i+1] <= qrs_pkg::DREM_W'(cur_m);
        qm[i+1] <= {qm[i][qrs_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  assign meta_out = meta[qrs_pkg::MAG_W];
  assign quo_p    = qp[qrs_pkg::MAG_W];
  assign quo_m    = qm[qrs_pkg::MAG_W];

endmodule

`default_nettype wire

### sv/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a x^2 + b x + c in fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     coef_a, coef_b, coef_c
//  result    done (strobe)    root_plus, root_minus, status
//
//  one item per cycle; each result passes the front stages, the 33-stage square root,
//  the add and magnitude registers, the 34-stage divider and the output register
//  busy is always low: the pipeline never stalls
//  synchronous reset clears all valid bits; items in flight are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  wire logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  wire logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  output logic                                   done,
  output logic signed [qrs_pkg::ROOT_W-1:0]      root_plus,
  output logic signed [qrs_pkg::ROOT_W-1:0]      root_minus,
  output logic [1:0]                             status
);

  // stage 1 registers
  logic                                s1_valid;
  logic                                s1_a_ok;
  logic signed [2*qrs_pkg::COEF_W-1:0] s1_bb;
  logic signed [2*qrs_pkg::COEF_W-1:0] s1_ac;
  logic signed [qrs_pkg::BASE_W-1:0]   s1_base;
  logic [qrs_pkg::DEN_W-1:0]           s1_den;

  // stage 2 registers
  qrs_pkg::meta_t                      s2_meta;
  logic [qrs_pkg::RAD_W-1:0]           s2_rad;
  logic signed [qrs_pkg::DISC_W-1:0]   disc;

  // square root output and later stages
  qrs_pkg::meta_t                      sq_meta;
  logic [qrs_pkg::SQ_W-1:0]            sq_root;
  qrs_pkg::meta_t                      p_meta;
  logic signed [qrs_pkg::ROOT_W-1:0]   p_num_p;
  logic signed [qrs_pkg::ROOT_W-1:0]   p_num_m;
  qrs_pkg::meta_t                      q_meta;
  logic [qrs_pkg::MAG_W-1:0]           q_mag_p;
  logic [qrs_pkg::MAG_W-1:0]           q_mag_m;
  logic [qrs_pkg::ROOT_W-1:0]          abs_p;
  logic [qrs_pkg::ROOT_W-1:0]          abs_m;
  qrs_pkg::meta_t                      d_meta;
  logic [qrs_pkg::MAG_W-1:0]           d_quo_p;
  logic [qrs_pkg::MAG_W-1:0]           d_quo_m;
  logic signed [qrs_pkg::ROOT_W-1:0]   sq_ext;

  assign busy = 1'b0;

  // products, scaled numerator base and denominator
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_a_ok <= (coef_a > 0);
    s1_bb   <= coef_b * coef_b;
    s1_ac   <= coef_a * coef_c;
    s1_base <= -(qrs_pkg::BASE_W'(coef_b) <<< qrs_pkg::FRAC);
    s1_den  <= {coef_a, 1'b0};
  end

  // discriminant and status
  assign disc = qrs_pkg::DISC_W'(s1_bb) - (qrs_pkg::DISC_W'(s1_ac) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_meta.valid <= 1'b0;
    end else begin
      s2_meta.valid <= s1_valid;
    end
    if (!s1_a_ok) begin
      s2_meta.status <= qrs_pkg::ST_BAD_A;
    end else if (disc > 0) begin
      s2_meta.status <= qrs_pkg::ST_TWO;
    end else begin
      s2_meta.status <= qrs_pkg::ST_NONE;
    end
    s2_meta.base  <= s1_base;
    s2_meta.den   <= s1_den;
    s2_meta.neg_p <= 1'b0;
    s2_meta.neg_m <= 1'b0;
    s2_rad        <= {1'b0, disc[qrs_pkg::SQ_W-1:0], {(2*qrs_pkg::FRAC){1'b0}}};
  end

  qrs_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .meta_in  (s2_meta),
    .rad_in   (s2_rad),
    .meta_out (sq_meta),
    .root_out (sq_root)
  );

  // numerators -b*2^16 +/- s
  assign sq_ext = $signed({2'b00, sq_root});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_meta.valid <= 1'b0;
    end else begin
      p_meta <= sq_meta;
    end
    p_num_p <= qrs_pkg::ROOT_W'(sq_meta.base) + sq_ext;
    p_num_m <= qrs_pkg::ROOT_W'(sq_meta.base) - sq_ext;
  end

  // sign and magnitude for the unsigned divider
  assign abs_p = p_num_p[qrs_pkg::ROOT_W-1] ? qrs_pkg::ROOT_W'(-p_num_p)
                                            : qrs_pkg::ROOT_W'(p_num_p);
  assign abs_m = p_num_m[qrs_pkg::ROOT_W-1] ? qrs_pkg::ROOT_W'(-p_num_m)
                                            : qrs_pkg::ROOT_W'(p_num_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_meta.valid <= 1'b0;
    end else begin
      q_meta.valid <= p_meta.valid;
    end
    q_meta.status <= p_meta.status;
    q_meta.base   <= p_meta.base;
    q_meta.den    <= p_meta.den;
    q_meta.neg_p  <= p_num_p[qrs_pkg::ROOT_W-1];
    q_meta.neg_m  <= p_num_m[qrs_pkg::ROOT_W-1];
    q_mag_p <= abs_p[qrs_pkg::MAG_W-1:0];
    q_mag_m <= abs_m[qrs_pkg::MAG_W-1:0];
  end

  qrs_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .meta_in  (q_meta),
    .mag_p_in (q_mag_p),
    .mag_m_in (q_mag_m),
    .meta_out (d_meta),
    .quo_p    (d_quo_p),
    .quo_m    (d_quo_m)
  );

  // restore sign, clear roots unless two real roots
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_meta.valid;
    end
    status <= d_meta.status;
    if (d_meta.status != qrs_pkg::ST_TWO) begin
      root_plus  <= '0;
      root_minus <= '0;
    end else begin
      root_plus  <= d_meta.neg_p ? -$signed({1'b0, d_quo_p}) : $signed({1'b0, d_quo_p});
      root_minus <= d_meta.neg_m ? -$signed({1'b0, d_quo_m}) : $signed({1'b0, d_quo_m});
    end
  end

endmodule

`default_nettype wire

### sv/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qrs_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic signed [qrs_pkg::COEF_W-1:0]   coef_a,
  input wire logic signed [qrs_pkg::COEF_W-1:0]   coef_b,
  input wire logic signed [qrs_pkg::COEF_W-1:0]   coef_c,
  input wire logic                                done,
  input wire logic signed [qrs_pkg::ROOT_W-1:0]   root_plus,
  input wire logic signed [qrs_pkg::ROOT_W-1:0]   root_minus,
  input wire logic [1:0]                          status
);

  // every result traces back to an earlier transfer
  `QRS_ASSERT_IMP(a_done_has_cmd, done, $past(start, qrs_pkg::LATENCY))

  // roots are zero unless two real roots were found
  `QRS_ASSERT_IMP(a_zero_roots, done && status != qrs_pkg::ST_TWO, root_plus == 0 && root_minus == 0)

  // plus root never lies below minus root
  `QRS_ASSERT_IMP(a_root_order, done && status == qrs_pkg::ST_TWO, root_plus >= root_minus)

  // pipeline never holds off a transfer
  `QRS_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

`default_nettype wire
